// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the converter RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

// ===== hdl/nvac_pkg.sv =====
// Shared types and constants for the NV21 to ARGB converter.
// No dependencies; imported by all converter modules.
`default_nettype none

package nvac_pkg;

   localparam int DIM_W  = 13;   // frame size register width
   localparam int OFF_W  = 24;   // destination index width
   localparam int ARGB_W = 32;

   // orientation codes
   localparam logic [1:0] ORIENT_STRAIGHT = 2'd0;
   localparam logic [1:0] ORIENT_REVERSED = 2'd1;
   localparam logic [1:0] ORIENT_CW       = 2'd2;
   localparam logic [1:0] ORIENT_CCW      = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_ORIENT = 2'd2;

   localparam logic [DIM_W-1:0] RESET_WIDTH  = 13'd640;
   localparam logic [DIM_W-1:0] RESET_HEIGHT = 13'd480;

   // BT.601, scaled by 1024
   localparam logic [7:0]  LUMA_FLOOR  = 8'd16;
   localparam logic [8:0]  CHROMA_BIAS = 9'd128;
   localparam int          COEF_Y      = 1192;
   localparam int          COEF_RV     = 1634;
   localparam int          COEF_GV     = 833;
   localparam int          COEF_GU     = 400;
   localparam int          COEF_BU     = 2066;
   localparam int          CLAMP_MAX   = 262143;
   localparam logic [7:0]  ALPHA       = 8'hff;

   // classified pixel handed from front to back
   typedef struct packed {
      logic [7:0]         luma_adj;   // luma - 16, floored at 0
      logic signed [8:0]  v;
      logic signed [8:0]  u;
      logic [DIM_W-1:0]   mul_a;      // dest = mul_a * height + addend
      logic [OFF_W-1:0]   addend;
      logic               last;
   } work_type;

   typedef struct packed {
      logic [ARGB_W-1:0]  pixel_argb;
      logic [OFF_W-1:0]   dest_index;
      logic               frame_last;
   } result_type;

   // effective frame geometry seen by the back end and checks
   typedef struct packed {
      logic [DIM_W-1:0]   width;
      logic [DIM_W-1:0]   height;
      logic [1:0]         orientation;
   } dims_type;

endpackage

`default_nettype wire

// ===== hdl/nv21_to_argb_convert.sv =====
// NV21 camera pixel to ARGB8888 converter with orientation index, one pixel per clock while req_full is low.
// A pushed pixel passes through the work queue, the multiply stage and the result queue before its result is visible.
// Throughput: one transaction per cycle unless the work queue is full or the result queue credit holds back issue.
// Reset (synchronous, active high): size 640x480, straight orientation, counters and
// held chroma cleared, both queues emptied.
// Depends on nvac_pkg, nvac_front, nvac_back, nvac_queue, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module nv21_to_argb_convert
   import nvac_pkg::*;
#(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // input pixels
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire logic [7:0]        req_luma,
   input  wire logic [7:0]        req_chroma_v,
   input  wire logic [7:0]        req_chroma_u,
   // results
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output logic [ARGB_W-1:0]      rsp_pixel_argb,
   output logic [OFF_W-1:0]       rsp_dest_index,
   output logic                   rsp_frame_last,
   // CSR write port
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [DIM_W-1:0]  csr_data
);

   localparam int WORK_DEPTH = 2;
   localparam int OUT_DEPTH  = 4;
   localparam int OUT_CW     = $clog2(OUT_DEPTH+1);
   localparam int WORK_CW    = $clog2(WORK_DEPTH+1);

   work_type            fe_work, be_work;
   dims_type            dims;
   result_type          be_result, out_head;
   logic                take;
   logic                work_full, work_empty;
   logic [WORK_CW-1:0]  work_count;
   logic                issue;
   logic                be_valid;
   logic                out_full;
   logic [OUT_CW-1:0]   out_count;

   // CSR writes are always taken; software must write only while idle, the block does not enforce it
   assign csr_ready = 1'b1;

   // front end takes a transaction whenever the work queue has space
   assign req_full = work_full;
   assign take     = req_push && !work_full;

   nvac_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .take      (take),
      .luma      (req_luma),
      .chroma_v  (req_chroma_v),
      .chroma_u  (req_chroma_u),
      .work      (fe_work),
      .dims      (dims)
   );

   // decouples pixel intake from the math pipe
   nvac_queue #(
      .WIDTH ($bits(work_type)),
      .DEPTH (WORK_DEPTH)
   ) u_work_q (
      .clock     (clock),
      .reset     (reset),
      .push      (take),
      .push_data (fe_work),
      .full      (work_full),
      .pop       (issue),
      .pop_data  (be_work),
      .empty     (work_empty),
      .count     (work_count)
   );

   // Credit check: one slot for the transaction in the multiply stage and one
   // for the one being issued, so the result queue can never overflow.
   assign issue = !work_empty && (out_count <= OUT_CW'(OUT_DEPTH - 2));

   nvac_back u_back (
      .clock        (clock),
      .reset        (reset),
      .issue        (issue),
      .work         (be_work),
      .eff_height   (dims.height),
      .result_valid (be_valid),
      .result       (be_result)
   );

   // result queue: lets intake continue while the consumer stalls
   nvac_queue #(
      .WIDTH ($bits(result_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_q (
      .clock     (clock),
      .reset     (reset),
      .push      (be_valid),
      .push_data (be_result),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (out_head),
      .empty     (rsp_empty),
      .count     (out_count)
   );

   assign rsp_pixel_argb = out_head.pixel_argb;
   assign rsp_dest_index = out_head.dest_index;
   assign rsp_frame_last = out_head.frame_last;

   // credit scheme must keep a slot free for every finished transaction
   `ASSERT_NEVER(a_out_overflow, clock, reset, be_valid && out_full)
   // queued work with credit available goes into the multiply stage next cycle
   `ASSERT_PROP(a_issue_progress, clock, reset,
                (!work_empty && out_count <= OUT_CW'(OUT_DEPTH - 2)) |=> be_valid)
   // every delivered pixel is opaque
   `ASSERT_PROP(a_alpha_opaque, clock, reset,
                !rsp_empty |-> rsp_pixel_argb[31:24] == ALPHA)
   // work queue count never exceeds its depth
   `ASSERT_NEVER(a_work_count, clock, reset, work_count > WORK_CW'(WORK_DEPTH))

endmodule

`default_nettype wire

// ===== hdl/nvac_queue.sv =====
// Small register FIFO used between converter stages.
// No package dependency; DEPTH must be a power of two.
`default_nettype none

module nvac_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire logic [WIDTH-1:0]           push_data,
   output logic                            full,
   input  wire logic                       pop,
   output logic [WIDTH-1:0]                pop_data,
   output logic                            empty,
   output logic [$clog2(DEPTH+1)-1:0]      count
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH+1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in;
   logic [PW-1:0]    rd_ff, rd_in;
   logic [CNTW-1:0]  cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == CNTW'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign count    = cnt_ff;
   assign pop_data = slot_ff[rd_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_in  = do_push ? PW'(wr_ff + 1'b1) : wr_ff;
      rd_in  = do_pop  ? PW'(rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/nvac_front.sv =====
// Front end: CSRs, raster counters, chroma latch, index operand setup.
// Depends on nvac_pkg.
`default_nettype none

module nvac_front
   import nvac_pkg::*;
#(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_valid,
   input  wire logic [1:0]        csr_index,
   input  wire logic [DIM_W-1:0]  csr_data,
   input  wire logic              take,
   input  wire logic [7:0]        luma,
   input  wire logic [7:0]        chroma_v,
   input  wire logic [7:0]        chroma_u,
   output work_type               work,
   output dims_type               dims
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   logic [DIM_W-1:0]   width_ff, width_in;
   logic [DIM_W-1:0]   height_ff, height_in;
   logic [1:0]         orient_ff, orient_in;
   logic [CW-1:0]      col_ff, col_in;
   logic [RW-1:0]      row_ff, row_in;
   logic [OFF_W-1:0]   off_ff, off_in;
   logic signed [8:0]  hv_ff, hv_in;
   logic signed [8:0]  hu_ff, hu_in;

   logic [DIM_W-1:0]   eff_w, eff_h, col_x, row_x;
   logic               col_end, row_end, restart;

   // clamp size to 2..MAX
   always_comb begin
      if (width_ff < DIM_W'(2)) begin
         eff_w = DIM_W'(2);
      end else if ({1'b0, width_ff} > (DIM_W+1)'(MAX_WIDTH)) begin
         eff_w = DIM_W'(MAX_WIDTH);
      end else begin
         eff_w = width_ff;
      end
      if (height_ff < DIM_W'(2)) begin
         eff_h = DIM_W'(2);
      end else if ({1'b0, height_ff} > (DIM_W+1)'(MAX_HEIGHT)) begin
         eff_h = DIM_W'(MAX_HEIGHT);
      end else begin
         eff_h = height_ff;
      end
   end

   assign dims  = '{width: eff_w, height: eff_h, orientation: orient_ff};
   assign col_x = DIM_W'(col_ff);
   assign row_x = DIM_W'(row_ff);

   assign col_end = ({1'b0, col_x} + 1'b1) >= {1'b0, eff_w};
   assign row_end = ({1'b0, row_x} + 1'b1) >= {1'b0, eff_h};

   // CSR writes; a size write restarts the frame
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      orient_in = orient_ff;
      restart   = 1'b0;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_WIDTH: begin
               width_in = csr_data;
               restart  = 1'b1;
            end
            CSR_HEIGHT: begin
               height_in = csr_data;
               restart   = 1'b1;
            end
            CSR_ORIENT: begin
               orient_in = csr_data[1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // chroma latched on even columns, biased to signed
   always_comb begin
      hv_in = hv_ff;
      hu_in = hu_ff;
      if (take && !col_ff[0]) begin
         hv_in = $signed({1'b0, chroma_v} - CHROMA_BIAS);
         hu_in = $signed({1'b0, chroma_u} - CHROMA_BIAS);
      end
   end

   // work entry for the current pixel
   always_comb begin
      work.luma_adj = (luma < LUMA_FLOOR) ? 8'd0 : 8'(luma - LUMA_FLOOR);
      work.v        = col_ff[0] ? hv_ff : hv_in;
      work.u        = col_ff[0] ? hu_ff : hu_in;
      work.last     = col_end && row_end;
      unique case (orient_ff)
         ORIENT_STRAIGHT: begin
            work.mul_a  = '0;
            work.addend = off_ff;
         end
         ORIENT_REVERSED: begin
            // w*h - 1 - off; ~off is -1-off mod 2^24
            work.mul_a  = eff_w;
            work.addend = ~off_ff;
         end
         ORIENT_CW: begin
            work.mul_a  = col_x;
            work.addend = OFF_W'(eff_h - DIM_W'(1) - row_x);
         end
         ORIENT_CCW: begin
            work.mul_a  = eff_w - DIM_W'(1) - col_x;
            work.addend = OFF_W'(row_x);
         end
         default: begin
            work.mul_a  = '0;
            work.addend = off_ff;
         end
      endcase
   end

   // raster position update
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      off_in = off_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
         off_in = '0;
      end else if (take) begin
         if (col_end) begin
            col_in = '0;
            if (row_end) begin
               row_in = '0;
               off_in = '0;
            end else begin
               row_in = RW'(row_ff + 1'b1);
               off_in = OFF_W'(off_ff + 1'b1);
            end
         end else begin
            col_in = CW'(col_ff + 1'b1);
            off_in = OFF_W'(off_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
         orient_ff <= ORIENT_STRAIGHT;
         col_ff    <= '0;
         row_ff    <= '0;
         off_ff    <= '0;
         hv_ff     <= '0;
         hu_ff     <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         orient_ff <= orient_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         off_ff    <= off_in;
         hv_ff     <= hv_in;
         hu_ff     <= hu_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/nvac_back.sv =====
// Back end: coefficient multiplies, clamp and pack, destination index.
// Depends on nvac_pkg.
`default_nettype none

module nvac_back
   import nvac_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              issue,
   input  work_type               work,
   input  wire logic [DIM_W-1:0]  eff_height,
   output logic                   result_valid,
   output result_type             result
);

   logic                      s1_valid_ff;
   logic [18:0]               y_ff, y_in;
   logic signed [20:0]        rv_ff, rv_in;
   logic signed [20:0]        gv_ff, gv_in;
   logic signed [20:0]        gu_ff, gu_in;
   logic signed [20:0]        bu_ff, bu_in;
   logic [2*DIM_W-1:0]        dprod_in;
   logic [OFF_W-1:0]          dprod_ff;
   logic [OFF_W-1:0]          add_ff;
   logic                      last_ff;

   logic signed [20:0]        y_s, rr, gg, bb;

   function automatic logic [7:0] chan8(input logic signed [20:0] x);
      if (x < 0) begin
         return 8'd0;
      end else if (x > 21'(CLAMP_MAX)) begin
         return 8'(CLAMP_MAX >> 10);
      end else begin
         return x[17:10];
      end
   endfunction

   // stage 1: products
   always_comb begin
      y_in     = 19'(work.luma_adj) * 19'(COEF_Y);
      rv_in    = $signed(21'(work.v)) * 21'(COEF_RV);
      gv_in    = $signed(21'(work.v)) * 21'(COEF_GV);
      gu_in    = $signed(21'(work.u)) * 21'(COEF_GU);
      bu_in    = $signed(21'(work.u)) * 21'(COEF_BU);
      dprod_in = (2*DIM_W)'(work.mul_a) * (2*DIM_W)'(eff_height);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         y_ff     <= y_in;
         rv_ff    <= rv_in;
         gv_ff    <= gv_in;
         gu_ff    <= gu_in;
         bu_ff    <= bu_in;
         dprod_ff <= dprod_in[OFF_W-1:0];
         add_ff   <= work.addend;
         last_ff  <= work.last;
      end
   end

   // stage 2: sums, clamp, pack
   assign y_s = $signed({2'b00, y_ff});
   assign rr  = y_s + rv_ff;
   assign gg  = y_s - gv_ff - gu_ff;
   assign bb  = y_s + bu_ff;

   assign result_valid      = s1_valid_ff;
   assign result.pixel_argb = {ALPHA, chan8(rr), chan8(gg), chan8(bb)};
   assign result.dest_index = dprod_ff + add_ff;
   assign result.frame_last = last_ff;

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for nv21_to_argb_convert: raster NV21 pixels in, ARGB8888 out.
// Predicts color, destination index and frame end per transaction; checks results in order.
// Depends on nvac_pkg and the converter RTL only.

module tb;
   import nvac_pkg::*;

   localparam int MAX_DIM     = 4096;  // both size parameters left at default
   localparam int STALL_LIMIT = 2000;  // cycles with no transaction on any port
   localparam int TAIL_CYCLES = 10;    // leave room for stray results after the pipeline drains
   localparam int RANDOM_ITEMS = 450;  // pixels sent with idling on both sides
   localparam int STEADY_ITEMS = 150;  // closing pixels with no idling at all

   // index past the register list, the block must drop the write
   localparam logic [1:0] CSR_UNMAPPED = 2'd3;

   // ---------------------------------------------------------------- DUT ports
   logic              clock        = 1'b0;
   logic              reset        = 1'b1;
   logic              req_push     = 1'b0;
   logic              req_full;
   logic [7:0]        req_luma     = '0;
   logic [7:0]        req_chroma_v = '0;
   logic [7:0]        req_chroma_u = '0;
   logic              rsp_empty;
   logic              rsp_pop      = 1'b0;
   logic [ARGB_W-1:0] rsp_pixel_argb;
   logic [OFF_W-1:0]  rsp_dest_index;
   logic              rsp_frame_last;
   logic              csr_valid    = 1'b0;
   logic              csr_ready;
   logic [1:0]        csr_index    = CSR_WIDTH;
   logic [DIM_W-1:0]  csr_data     = '0;

   nv21_to_argb_convert u_top (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_luma       (req_luma),
      .req_chroma_v   (req_chroma_v),
      .req_chroma_u   (req_chroma_u),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_pixel_argb (rsp_pixel_argb),
      .rsp_dest_index (rsp_dest_index),
      .rsp_frame_last (rsp_frame_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------- predictor state
   // register copies as written, raw 13-bit values (clamping happens on use)
   logic [DIM_W-1:0]  cfg_width;
   logic [DIM_W-1:0]  cfg_height;
   logic [1:0]        cfg_orient;
   // position of the next pixel in the source frame
   int unsigned       next_col;
   int unsigned       next_row;
   logic [OFF_W-1:0]  raster_pos;     // next_row * W + next_col
   // chroma pair minus bias, latched on even columns
   logic signed [8:0] hold_v;
   logic signed [8:0] hold_u;

   result_type        expected_pixels[$];

   bit                steady_flow  = 1'b0;  // no idling on either side when set
   int                error_count  = 0;
   int                pixels_sent  = 0;
   int                stall_cycles = 0;
   int                pop_hold     = 0;

   function automatic int effective_dim(logic [DIM_W-1:0] raw);
      if (raw < 2) return 2;
      if (raw > MAX_DIM) return MAX_DIM;
      return int'(raw);
   endfunction

   // clamp a scaled channel to 18 bits and keep the top byte
   function automatic logic [7:0] channel_byte(int acc);
      logic [17:0] sat;
      if (acc < 0) sat = '0;
      else if (acc > 262143) sat = '1;
      else sat = 18'(acc);
      return sat[17:10];
   endfunction

   // color conversion, index for the current orientation, then advance position
   function automatic result_type convert_pixel(logic [7:0] y_in, logic [7:0] v_in,
                                                logic [7:0] u_in);
      int         w;
      int         h;
      int         y;
      int         dest;
      result_type res;
      w = effective_dim(cfg_width);
      h = effective_dim(cfg_height);
      y = (y_in < 8'd16) ? 0 : int'(y_in) - 16;
      if (next_col[0] == 1'b0) begin
         hold_v = 9'(int'(v_in) - 128);
         hold_u = 9'(int'(u_in) - 128);
      end
      res.pixel_argb = {8'hff,
                        channel_byte(1192 * y + 1634 * int'(hold_v)),
                        channel_byte(1192 * y - 833 * int'(hold_v) - 400 * int'(hold_u)),
                        channel_byte(1192 * y + 2066 * int'(hold_u))};
      dest = 0;
      case (cfg_orient)
         ORIENT_STRAIGHT: dest = int'(raster_pos);
         ORIENT_REVERSED: dest = w * h - 1 - int'(raster_pos);
         ORIENT_CW:       dest = int'(next_col) * h + (h - 1 - int'(next_row));
         ORIENT_CCW:      dest = (w - 1 - int'(next_col)) * h + int'(next_row);
      endcase
      res.dest_index = OFF_W'(dest);
      res.frame_last = (next_col + 1 >= w) && (next_row + 1 >= h);
      if (next_col + 1 >= w) begin
         next_col = 0;
         if (next_row + 1 >= h) begin
            next_row   = 0;
            raster_pos = '0;
         end else begin
            next_row++;
            raster_pos++;
         end
      end else begin
         next_col++;
         raster_pos++;
      end
      return res;
   endfunction

   // size writes restart the frame; held chroma survives
   function automatic void apply_register(logic [1:0] idx, logic [DIM_W-1:0] value);
      if (idx == CSR_WIDTH || idx == CSR_HEIGHT) begin
         if (idx == CSR_WIDTH) cfg_width = value;
         else cfg_height = value;
         next_col   = 0;
         next_row   = 0;
         raster_pos = '0;
      end else if (idx == CSR_ORIENT) begin
         cfg_orient = value[1:0];
      end
   endfunction

   // extremes show up often so clamping and saturation get exercised
   function automatic logic [7:0] random_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hff;
         2:       return 8'h10;
         default: return 8'($urandom);
      endcase
   endfunction

   // mostly tiny frames so frame ends and wraps are frequent
   function automatic int pick_dim();
      case ($urandom_range(0, 15))
         0:       return $urandom_range(0, 1);
         1:       return $urandom_range(MAX_DIM + 1, 8191);
         2:       return $urandom_range(10, MAX_DIM);
         default: return $urandom_range(2, 9);
      endcase
   endfunction

   // ------------------------------------------------------ stimulus helpers
   // one pixel transaction; optional idle burst in front of it
   task automatic send_pixel(logic [7:0] y, logic [7:0] v, logic [7:0] u);
      if (!steady_flow && $urandom_range(0, 5) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_push     <= 1'b1;
      req_luma     <= y;
      req_chroma_v <= v;
      req_chroma_u <= u;
      do @(posedge clock); while (req_full);
      expected_pixels.push_back(convert_pixel(y, v, u));
      pixels_sent++;
   endtask

   // stop pushing and let every outstanding result drain
   task automatic quiesce();
      req_push <= 1'b0;
      do @(posedge clock); while (expected_pixels.size() != 0);
   endtask

   // leaves csr_valid high so back-to-back writes need no extra edge
   task automatic csr_write(logic [1:0] idx, logic [DIM_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      apply_register(idx, value);
   endtask

   task automatic configure(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
                            logic [DIM_W-1:0] orient);
      quiesce();
      csr_write(CSR_WIDTH, w);
      csr_write(CSR_HEIGHT, h);
      csr_write(CSR_ORIENT, orient);
      csr_valid <= 1'b0;
   endtask

   task automatic write_one_register(logic [1:0] idx, logic [DIM_W-1:0] value);
      quiesce();
      csr_write(idx, value);
      csr_valid <= 1'b0;
   endtask

   // random geometry per phase; one to three whole frames plus a partial one when small, a slice when large
   task automatic run_frames(int target);
      int w_raw;
      int h_raw;
      int area;
      int count;
      while (pixels_sent < target) begin
         w_raw = pick_dim();
         h_raw = pick_dim();
         configure(DIM_W'(w_raw), DIM_W'(h_raw), DIM_W'($urandom));
         area = effective_dim(DIM_W'(w_raw)) * effective_dim(DIM_W'(h_raw));
         if (area <= 64) count = area * $urandom_range(1, 3) + $urandom_range(0, area - 1);
         else count = $urandom_range(1, 40);
         // stay close to the requested pixel total
         if (count > target - pixels_sent) count = target - pixels_sent;
         repeat (count) begin
            // occasional orientation change or dropped write partway into a frame
            if ($urandom_range(0, 60) == 0) begin
               if ($urandom_range(0, 1) == 1) write_one_register(CSR_ORIENT, DIM_W'($urandom));
               else write_one_register(CSR_UNMAPPED, DIM_W'($urandom));
            end
            send_pixel(random_byte(), random_byte(), random_byte());
         end
      end
   endtask

   // --------------------------------------------------------------- tests
   // registers at reset values (640x480 straight); color extremes, luma floor,
   // and chroma held from the even column for the odd one
   task automatic test_reset_state_colors();
      send_pixel(8'd0,   8'd0,   8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);   // odd column: pair from column 0 used
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd15,  8'd0,   8'd255);   // luma below floor
      send_pixel(8'd16,  8'd128, 8'd128);
      send_pixel(8'd235, 8'd0,   8'd0);
      send_pixel(8'd128, 8'd255, 8'd0);
      send_pixel(8'd128, 8'd0,   8'd255);
   endtask

   // full 2x2 frames in every orientation, sizes written below the minimum
   task automatic test_orientations();
      logic [1:0] codes[4] = '{ORIENT_STRAIGHT, ORIENT_REVERSED, ORIENT_CW, ORIENT_CCW};
      for (int i = 0; i < 4; i++) begin
         configure(DIM_W'(i % 2), DIM_W'(1 - i % 2),
                   DIM_W'({11'($urandom), codes[i]}));
         repeat (4) send_pixel(random_byte(), random_byte(), random_byte());
      end
   endtask

   // sizes above the maximum, orientation switched mid-frame, unmapped index
   task automatic test_size_limits();
      configure(13'h1fff, 13'h1fff, DIM_W'(ORIENT_REVERSED));
      send_pixel(8'd200, 8'd60, 8'd190);
      send_pixel(8'd90,  8'd240, 8'd20);
      write_one_register(CSR_ORIENT, DIM_W'(ORIENT_CCW));
      send_pixel(8'd50, 8'd128, 8'd128);
      write_one_register(CSR_UNMAPPED, 13'h1fff);
      send_pixel(8'd170, 8'd10, 8'd250);
   endtask

   task automatic test_random_frames();
      run_frames(pixels_sent + RANDOM_ITEMS);
   endtask

   task automatic test_back_to_back();
      steady_flow = 1'b1;
      run_frames(pixels_sent + STEADY_ITEMS);
   endtask

   // ------------------------------------------------------ result side
   // pop stays high except for random stall bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop  <= 1'b0;
         pop_hold <= 0;
      end else if (pop_hold > 1) begin
         pop_hold <= pop_hold - 1;
      end else if (!steady_flow && pop_hold == 0 && $urandom_range(0, 11) == 0) begin
         rsp_pop  <= 1'b0;
         pop_hold <= $urandom_range(1, 15);
      end else begin
         rsp_pop  <= 1'b1;
         pop_hold <= 0;
      end
   end

   // compare each popped transaction with the oldest prediction
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected result: argb %08h index %0d last %0b",
                   rsp_pixel_argb, rsp_dest_index, rsp_frame_last);
            error_count++;
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_pixel_argb !== want.pixel_argb) begin
               $error("pixel_argb expected %08h got %08h", want.pixel_argb, rsp_pixel_argb);
               error_count++;
            end
            if (rsp_dest_index !== want.dest_index) begin
               $error("dest_index expected %0d got %0d", want.dest_index, rsp_dest_index);
               error_count++;
            end
            if (rsp_frame_last !== want.frame_last) begin
               $error("frame_last expected %0b got %0b", want.frame_last, rsp_frame_last);
               error_count++;
            end
         end
      end
   end

   // watchdog: any transaction on any port resets the count
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog expired, %0d results outstanding", expected_pixels.size());
         $display("nv21_to_argb_convert verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // ------------------------------------------------------------ sequence
   initial begin
      cfg_width  = 13'd640;
      cfg_height = 13'd480;
      cfg_orient = ORIENT_STRAIGHT;
      next_col   = 0;
      next_row   = 0;
      raster_pos = '0;
      hold_v     = '0;
      hold_u     = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_reset_state_colors();
      test_orientations();
      test_size_limits();
      test_random_frames();
      test_back_to_back();

      // drain, then give stray results time to show up
      req_push <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("nv21_to_argb_convert verification clean");
      end else begin
         $display("nv21_to_argb_convert verification failed");
      end
      $finish;
   end

endmodule
